@@ sv/elc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elc_pkg: shared types and constants of the elevator controller
// Holds the word formats of both channels, the register set, the event,
// mode and heading codes, and the reset values of the registers.
// ----------------------------------------------------------------------------
package elc_pkg;

   localparam int FLOORS_DEF = 16;

   // event codes
   localparam logic [1:0] OP_CALL   = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_CLOSED = 2'd2;

   // car modes
   localparam logic [1:0] MODE_WAIT = 2'd0;
   localparam logic [1:0] MODE_UP   = 2'd1;
   localparam logic [1:0] MODE_DOWN = 2'd2;
   localparam logic [1:0] MODE_OPEN = 2'd3;

   // headings
   localparam logic [1:0] HEAD_IDLE = 2'd0;
   localparam logic [1:0] HEAD_UP   = 2'd1;
   localparam logic [1:0] HEAD_DOWN = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_LOWEST  = 2'd0;
   localparam logic [1:0] CSR_HIGHEST = 2'd1;
   localparam logic [1:0] CSR_TICKS   = 2'd2;

   localparam logic [3:0]  LOWEST_RESET  = 4'd1;
   localparam logic [3:0]  HIGHEST_RESET = 4'd5;
   localparam logic [15:0] TICKS_RESET   = 16'd1500;

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] call_floor;
   } req_type;

   typedef struct packed {
      logic [3:0] car_floor;
      logic [1:0] car_mode;
      logic [1:0] heading;
      logic       open_command;
      logic       bad_call;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  lowest_floor;
      logic [3:0]  highest_floor;
      logic [15:0] travel_ticks;
   } cfg_type;

   typedef struct packed {
      logic any_up;
      logic any_down;
   } pick_type;

endpackage

@@ sv/elevator_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_controller: single-car lift controller
// Takes one event word per cycle while req_stall is low (floor call, time tick,
// doors closed) and returns one status word per event: floor, mode, heading,
// door-open pulse and a flag for a call outside the served floors.
//
// Channels: req_valid/req_stall/req_word carry events in, rsp_valid/
// rsp_stall/rsp_word carry status out. A word moves on a rising edge with
// valid high and stall low. The csr_ port writes lowest floor, highest floor
// and ticks per floor on any edge with csr_write high; write only when idle.
//
// The event is held in the event register; the status word of that event
// lands in the status register. Throughput: one event per cycle while
// rsp_stall is low; the event register feeds the state and next-state logic.
// While rsp_stall holds, the status word and one further event are held;
// req_stall rises once both registers are full.
// Reset: no pending calls, car at floor 1 waiting with heading idle, travel
// count zero, registers back to 1, 5 and 1500, both channels empty.
// ----------------------------------------------------------------------------
module elevator_controller #(
   parameter int FLOORS = elc_pkg::FLOORS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  elc_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output elc_pkg::rsp_type rsp_word,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);

   elc_pkg::cfg_type cfg_ff;
   logic             s1_valid_ff, s1_valid_in;
   elc_pkg::req_type s1_item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   elc_pkg::rsp_type rsp_item_ff;
   elc_pkg::rsp_type core_rsp;
   logic             advance;
   logic             take;

   assign advance     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !advance;
   assign take        = req_valid && !req_stall;
   assign s1_valid_in = take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   elc_core #(.FLOORS(FLOORS)) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .en    (advance),
      .item  (s1_item_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lowest_floor  <= elc_pkg::LOWEST_RESET;
         cfg_ff.highest_floor <= elc_pkg::HIGHEST_RESET;
         cfg_ff.travel_ticks  <= elc_pkg::TICKS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            elc_pkg::CSR_LOWEST:  cfg_ff.lowest_floor  <= csr_data[3:0];
            elc_pkg::CSR_HIGHEST: cfg_ff.highest_floor <= csr_data[3:0];
            elc_pkg::CSR_TICKS:   cfg_ff.travel_ticks  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) s1_item_ff <= req_word;
      if (advance) rsp_item_ff <= core_rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_item_ff;

endmodule

@@ sv/elc_pick.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elc_pick: pending-call search
// Reports whether a served floor above or below the car has a pending call.
// ----------------------------------------------------------------------------
module elc_pick #(
   parameter int FLOORS = elc_pkg::FLOORS_DEF
) (
   input  logic [FLOORS-1:0] pending,
   input  logic [3:0]        floor_now,
   input  logic [3:0]        lo,
   input  logic [3:0]        hi,
   output elc_pkg::pick_type pick
);

   always_comb begin
      pick = '0;
      for (int f = 0; f < FLOORS; f++) begin
         if (pending[f] && f >= int'(lo) && f <= int'(hi)) begin
            if (f > int'(floor_now)) pick.any_up   = 1'b1;
            if (f < int'(floor_now)) pick.any_down = 1'b1;
         end
      end
   end

endmodule

@@ sv/elc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elc_core: car state and event handling
// Holds the pending calls, floor, mode, heading and travel count, and works
// out the next state and the result word of one event.
// ----------------------------------------------------------------------------
module elc_core #(
   parameter int FLOORS = elc_pkg::FLOORS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  elc_pkg::cfg_type cfg,
   input  logic             en,
   input  elc_pkg::req_type item,
   output elc_pkg::rsp_type rsp
);

   localparam int TopIdx = FLOORS - 1;

   logic [FLOORS-1:0] pending_ff, pending_in, pend_src;
   logic [3:0]        floor_ff, floor_in;
   logic [1:0]        mode_ff, mode_in;
   logic [1:0]        head_ff, head_in;
   logic [15:0]       count_ff, count_in;

   logic [3:0]        hi_eff;
   logic              bad_req;
   logic              cur_served;
   logic [15:0]       cnt1;
   logic [15:0]       limit;
   logic signed [5:0] nxt;
   logic              nxt_ok;
   logic              go_down;
   logic              do_pick;
   logic              opened;
   logic              bad;
   elc_pkg::pick_type pick;

   function automatic logic bit_at(input logic [FLOORS-1:0] v, input int f);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < FLOORS; i++)
         if (i == f) hit = v[i];
      return hit;
   endfunction

   function automatic logic [FLOORS-1:0] hot(input int f);
      logic [FLOORS-1:0] v;
      v = '0;
      for (int i = 0; i < FLOORS; i++)
         if (i == f) v[i] = 1'b1;
      return v;
   endfunction

   assign hi_eff = (int'(cfg.highest_floor) > TopIdx) ? 4'(TopIdx) : cfg.highest_floor;
   assign bad_req = (item.call_floor < cfg.lowest_floor) || (item.call_floor > hi_eff);
   assign cur_served = (floor_ff >= cfg.lowest_floor) && (floor_ff <= hi_eff);
   assign pend_src = (item.op == elc_pkg::OP_CALL && !bad_req)
                     ? (pending_ff | hot(int'(item.call_floor))) : pending_ff;

   assign cnt1  = count_ff + 16'd1;
   assign limit = (cfg.travel_ticks == 16'd0) ? 16'd1 : cfg.travel_ticks;
   assign nxt   = (mode_ff == elc_pkg::MODE_UP) ? $signed({2'b00, floor_ff}) + 6'sd1
                                                : $signed({2'b00, floor_ff}) - 6'sd1;
   assign nxt_ok = (nxt >= $signed({2'b00, cfg.lowest_floor}))
                && (nxt <= $signed({2'b00, hi_eff}));
   assign go_down = (head_ff == elc_pkg::HEAD_DOWN) ? pick.any_down : !pick.any_up;

   elc_pick #(.FLOORS(FLOORS)) u_pick (
      .pending   (pend_src),
      .floor_now (floor_ff),
      .lo        (cfg.lowest_floor),
      .hi        (hi_eff),
      .pick      (pick)
   );

   always_comb begin
      pending_in = pending_ff;
      floor_in   = floor_ff;
      mode_in    = mode_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      opened     = 1'b0;
      bad        = 1'b0;
      do_pick    = 1'b0;
      unique case (item.op)
         elc_pkg::OP_CALL: begin
            if (bad_req) begin
               bad = 1'b1;
            end else begin
               pending_in = pend_src;
               if (mode_ff == elc_pkg::MODE_WAIT) do_pick = 1'b1;
            end
         end
         elc_pkg::OP_TICK: begin
            if (mode_ff == elc_pkg::MODE_UP || mode_ff == elc_pkg::MODE_DOWN) begin
               count_in = cnt1;
               if (cnt1 >= limit) begin
                  count_in = '0;
                  if (!nxt_ok) begin
                     mode_in = elc_pkg::MODE_WAIT;
                     head_in = elc_pkg::HEAD_IDLE;
                  end else begin
                     floor_in = nxt[3:0];
                     if (bit_at(pending_ff, int'(nxt[3:0]))) begin
                        pending_in = pending_ff & ~hot(int'(nxt[3:0]));
                        mode_in    = elc_pkg::MODE_OPEN;
                        opened     = 1'b1;
                     end
                  end
               end
            end
         end
         elc_pkg::OP_CLOSED: begin
            if (mode_ff == elc_pkg::MODE_OPEN) do_pick = 1'b1;
         end
         default: begin
         end
      endcase
      if (do_pick) begin
         if (cur_served && bit_at(pend_src, int'(floor_ff))) begin
            pending_in = pend_src & ~hot(int'(floor_ff));
            mode_in    = elc_pkg::MODE_OPEN;
            opened     = 1'b1;
         end else if (!pick.any_up && !pick.any_down) begin
            mode_in = elc_pkg::MODE_WAIT;
            head_in = elc_pkg::HEAD_IDLE;
         end else if (go_down) begin
            mode_in  = elc_pkg::MODE_DOWN;
            head_in  = elc_pkg::HEAD_DOWN;
            count_in = '0;
         end else begin
            mode_in  = elc_pkg::MODE_UP;
            head_in  = elc_pkg::HEAD_UP;
            count_in = '0;
         end
      end
   end

   always_comb begin
      rsp.car_floor    = floor_in;
      rsp.car_mode     = mode_in;
      rsp.heading      = head_in;
      rsp.open_command = opened;
      rsp.bad_call     = bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         floor_ff   <= elc_pkg::LOWEST_RESET;
         mode_ff    <= elc_pkg::MODE_WAIT;
         head_ff    <= elc_pkg::HEAD_IDLE;
         count_ff   <= '0;
      end else if (en) begin
         pending_ff <= pending_in;
         floor_ff   <= floor_in;
         mode_ff    <= mode_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
      end
   end

endmodule

@@ sv/elc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elc_checker: port-level checks of the elevator controller
// Watches the status channel for words that break the car's own rules.
// ----------------------------------------------------------------------------
module elc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input elc_pkg::rsp_type rsp_word
);

   a_bad_no_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.bad_call |-> !rsp_word.open_command)
      else $error("door opened on a rejected call");

   a_open_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.open_command |-> rsp_word.car_mode == elc_pkg::MODE_OPEN)
      else $error("open pulse without doors-open mode");

   a_move_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.car_mode == elc_pkg::MODE_UP
                    || rsp_word.car_mode == elc_pkg::MODE_DOWN)
      |-> rsp_word.heading == rsp_word.car_mode)
      else $error("car moving against its heading");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled status word changed");

endmodule

bind elevator_controller elc_checker u_elc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
